// ===== hdl/dcct_pkg.sv =====
// Shared types, widths and codes for the detection cluster confirmation table.
`timescale 1ns / 1ps

package dcct_pkg;

    // Field widths
    localparam int COORD_W = 16;
    localparam int ID_W    = 16;
    localparam int HITS_W  = 8;
    localparam int TOL_W   = 12;
    localparam int CONF_W  = 8;
    localparam int CFG_W   = 12;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int TOL2_W  = 2 * TOL_W;

    // Default table geometry
    localparam int DEF_SLOTS_PER_ZONE = 128;
    localparam int DEF_ZONE_COUNT     = 4;

    // Register reset values and the hit-count limit
    localparam logic [TOL_W-1:0]  TOL_RESET  = 12'd200;
    localparam logic [CONF_W-1:0] CONF_RESET = 8'd20;
    localparam logic [HITS_W-1:0] HITS_MAX   = 8'hFF;

    // Configuration register indexes
    localparam logic CFG_TOL  = 1'b0;
    localparam logic CFG_CONF = 1'b1;

    // Item function codes
    localparam logic FUNC_ASSOC  = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MATCHED   = 3'd0,
        ST_ADDED     = 3'd1,
        ST_DISCARDED = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // One stored candidate
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [HITS_W-1:0]         hits;
        logic [ID_W-1:0]           ident;
        logic                      confirmed;
    } slot_t;

endpackage

// ===== hdl/detection_cluster_confirm_table.sv =====
// Top level: per-zone candidate table with distance gating and hit-count confirmation.
//
// Usage: an input word (valid/stall) either associates a detection with its zone's
// table or removes every entry with a given id from all zones. Each input word
// yields exactly one result word on the output channel (valid/stall).
// Configuration (tolerance, confirm count) is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while the block is idle, the block does not check.
// A detection for a zone beyond ZONE_COUNT is discarded at once; others square the
// tolerance, scan the entries of their zone (at most SLOTS_PER_ZONE) until the first
// match, and add a new entry, or discard when the zone is full, if none matches.
// Each scanned entry goes through one table read (S_RD), two passes of the single
// shared squaring multiplier (S_DX, S_DY), then the compare (S_CMP). A remove reads
// and checks each entry of every zone in turn through the single table read port,
// and closes each zone by storing its new fill count.
// in_stall is high from acceptance until the result is placed in the output
// register; the block takes one item at a time, the next one at the earliest in the
// cycle after the previous result is loaded.
// If the receiver stalls, the result waits in the output register; a following
// item is accepted and worked on, and its result waits in the block until the
// output register is free.
// Reset clears all fill counts (empty tables), the id counter, and restores the
// tolerance to 200 mm and the confirm count to 20. No clearing pass is needed.
`timescale 1ns / 1ps

module detection_cluster_confirm_table #(
    parameter int SLOTS_PER_ZONE = dcct_pkg::DEF_SLOTS_PER_ZONE,
    parameter int ZONE_COUNT     = dcct_pkg::DEF_ZONE_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [dcct_pkg::CFG_W-1:0]          cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [1:0]                          zone,
    input  logic signed [dcct_pkg::COORD_W-1:0] pos_x,
    input  logic signed [dcct_pkg::COORD_W-1:0] pos_y,
    input  logic [dcct_pkg::ID_W-1:0]           target_id,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic [dcct_pkg::ID_W-1:0]           entry_id,
    output logic                                newly_confirmed
);
    import dcct_pkg::*;

    localparam int TOTAL   = SLOTS_PER_ZONE * ZONE_COUNT;
    localparam int AW      = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CNT_W   = $clog2(SLOTS_PER_ZONE + 1);
    localparam int ZIDX_W  = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int SLOT_W  = $bits(slot_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOL,
        S_TOLW,
        S_RD,
        S_DX,
        S_DY,
        S_CMP,
        S_ADD,
        S_RM_RD,
        S_RM_CHK,
        S_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic [TOL_W-1:0]           tol_reg, tol_next;
    logic [CONF_W-1:0]          conf_reg, conf_next;
    logic [CNT_W-1:0]           cnt_reg [ZONE_COUNT];
    logic [CNT_W-1:0]           cnt_next [ZONE_COUNT];
    logic [ID_W-1:0]            nid_reg, nid_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           wptr_reg, wptr_next;
    logic [ZIDX_W-1:0]          zsel_reg, zsel_next;
    logic [AW-1:0]              base_reg, base_next;
    logic                       found_reg, found_next;
    logic signed [COORD_W-1:0]  px_reg, px_next;
    logic signed [COORD_W-1:0]  py_reg, py_next;
    logic [ID_W-1:0]            tid_reg, tid_next;
    logic [TOL2_W-1:0]          tol2_reg, tol2_next;
    logic [SQ_W-1:0]            sqx_reg, sqx_next;
    status_t                    res_st_reg, res_st_next;
    logic [ID_W-1:0]            res_id_reg, res_id_next;
    logic                       res_nc_reg, res_nc_next;
    logic                       out_valid_reg, out_valid_next;
    status_t                    out_st_reg, out_st_next;
    logic [ID_W-1:0]            out_id_reg, out_id_next;
    logic                       out_nc_reg, out_nc_next;

    // table and shared unit hookup
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    slot_t                      ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [SLOT_W-1:0]          ram_rdata;
    slot_t                      rd_slot;
    logic                       sq_en;
    logic signed [COORD_W-1:0]  sq_a;
    logic signed [COORD_W-1:0]  sq_b;
    logic [SQ_W-1:0]            sq_prod;

    dcct_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TOTAL)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dcct_sq_unit u_sq (
        .clk  (clk),
        .en   (sq_en),
        .a    (sq_a),
        .b    (sq_b),
        .prod (sq_prod)
    );

    assign rd_slot = slot_t'(ram_rdata);

    // Sequencer: next state, table accesses and shared unit control
    always_comb
    begin
        logic [CNT_W-1:0]  idx_inc;
        logic [CNT_W-1:0]  zcnt;
        logic [SQ_W:0]     dist2;
        logic [HITS_W-1:0] hits_new;
        logic              newc;
        logic              out_free;

        state_next     = state_reg;
        tol_next       = tol_reg;
        conf_next      = conf_reg;
        cnt_next       = cnt_reg;
        nid_next       = nid_reg;
        idx_next       = idx_reg;
        wptr_next      = wptr_reg;
        zsel_next      = zsel_reg;
        base_next      = base_reg;
        found_next     = found_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        tid_next       = tid_reg;
        tol2_next      = tol2_reg;
        sqx_next       = sqx_reg;
        res_st_next    = res_st_reg;
        res_id_next    = res_id_reg;
        res_nc_next    = res_nc_reg;
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_id_next    = out_id_reg;
        out_nc_next    = out_nc_reg;

        ram_we    = 1'b0;
        ram_waddr = base_reg + AW'(idx_reg);
        ram_wdata = rd_slot;
        ram_re    = 1'b0;
        ram_raddr = base_reg + AW'(idx_reg);
        sq_en     = 1'b0;
        sq_a      = rd_slot.x;
        sq_b      = px_reg;

        idx_inc  = idx_reg + CNT_W'(1);
        zcnt     = cnt_reg[zsel_reg];
        dist2    = {1'b0, sqx_reg} + {1'b0, sq_prod};
        hits_new = (rd_slot.hits == HITS_MAX) ? rd_slot.hits : rd_slot.hits + HITS_W'(1);
        newc     = (hits_new >= conf_reg) && !rd_slot.confirmed;
        out_free = !out_valid_reg || !out_stall;

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOL:  tol_next  = cfg_data[TOL_W-1:0];
                CFG_CONF: conf_next = cfg_data[CONF_W-1:0];
                default:  ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    px_next    = pos_x;
                    py_next    = pos_y;
                    tid_next   = target_id;
                    idx_next   = '0;
                    wptr_next  = '0;
                    found_next = 1'b0;
                    res_nc_next = 1'b0;
                    if (func == FUNC_REMOVE)
                    begin
                        zsel_next  = '0;
                        base_next  = '0;
                        state_next = S_RM_RD;
                    end
                    else if (32'(zone) >= ZONE_COUNT)
                    begin
                        res_st_next = ST_DISCARDED;
                        res_id_next = '0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        zsel_next  = ZIDX_W'(zone);
                        base_next  = AW'(ZIDX_W'(zone)) * AW'(SLOTS_PER_ZONE);
                        state_next = S_TOL;
                    end
                end
            end

            // square the tolerance on the shared unit
            S_TOL:
            begin
                sq_en      = 1'b1;
                sq_a       = signed'(COORD_W'(tol_reg));
                sq_b       = '0;
                state_next = S_TOLW;
            end

            S_TOLW:
            begin
                tol2_next  = sq_prod[TOL2_W-1:0];
                state_next = (zcnt == '0) ? S_ADD : S_RD;
            end

            // fetch the next entry of the zone
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_DX;
            end

            S_DX:
            begin
                sq_en      = 1'b1;
                sq_a       = rd_slot.x;
                sq_b       = px_reg;
                state_next = S_DY;
            end

            S_DY:
            begin
                sq_en      = 1'b1;
                sq_a       = rd_slot.y;
                sq_b       = py_reg;
                sqx_next   = sq_prod;
                state_next = S_CMP;
            end

            // gate on squared distance; update the first match in place
            S_CMP:
            begin
                if (dist2 < (SQ_W+1)'(tol2_reg))
                begin
                    ram_we              = 1'b1;
                    ram_wdata           = rd_slot;
                    ram_wdata.hits      = hits_new;
                    ram_wdata.confirmed = rd_slot.confirmed || newc;
                    res_st_next         = ST_MATCHED;
                    res_id_next         = rd_slot.ident;
                    res_nc_next         = newc;
                    state_next          = S_OUT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == zcnt) ? S_ADD : S_RD;
                end
            end

            // append a new entry unless the zone is full
            S_ADD:
            begin
                if (zcnt == CNT_W'(SLOTS_PER_ZONE))
                begin
                    res_st_next = ST_DISCARDED;
                    res_id_next = '0;
                end
                else
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = base_reg + AW'(zcnt);
                    ram_wdata.x         = px_reg;
                    ram_wdata.y         = py_reg;
                    ram_wdata.hits      = HITS_W'(1);
                    ram_wdata.ident     = nid_reg;
                    ram_wdata.confirmed = 1'b0;
                    cnt_next[zsel_reg]  = zcnt + CNT_W'(1);
                    nid_next            = nid_reg + ID_W'(1);
                    res_st_next         = ST_ADDED;
                    res_id_next         = nid_reg;
                end
                state_next = S_OUT;
            end

            // remove: read each entry of each zone, or close the zone
            S_RM_RD:
            begin
                if (idx_reg == zcnt)
                begin
                    cnt_next[zsel_reg] = wptr_reg;
                    idx_next           = '0;
                    wptr_next          = '0;
                    if (32'(zsel_reg) == ZONE_COUNT - 1)
                    begin
                        res_st_next = found_reg ? ST_REMOVED : ST_NOT_FOUND;
                        res_id_next = tid_reg;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        zsel_next = zsel_reg + ZIDX_W'(1);
                        base_next = base_reg + AW'(SLOTS_PER_ZONE);
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_RM_CHK;
                end
            end

            // skip matching ids, move the rest down to close the gap
            S_RM_CHK:
            begin
                if (rd_slot.ident == tid_reg)
                begin
                    found_next = 1'b1;
                end
                else
                begin
                    if (wptr_reg != idx_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = base_reg + AW'(wptr_reg);
                        ram_wdata = rd_slot;
                    end
                    wptr_next = wptr_reg + CNT_W'(1);
                end
                idx_next   = idx_inc;
                state_next = S_RM_RD;
            end

            // hand the result to the output register when it is free
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_id_next    = res_id_reg;
                    out_nc_next    = res_nc_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= TOL_RESET;
            conf_reg      <= CONF_RESET;
            cnt_reg       <= '{default: '0};
            nid_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tol_reg       <= tol_next;
            conf_reg      <= conf_next;
            cnt_reg       <= cnt_next;
            nid_reg       <= nid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        wptr_reg   <= wptr_next;
        zsel_reg   <= zsel_next;
        base_reg   <= base_next;
        found_reg  <= found_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        tid_reg    <= tid_next;
        tol2_reg   <= tol2_next;
        sqx_reg    <= sqx_next;
        res_st_reg <= res_st_next;
        res_id_reg <= res_id_next;
        res_nc_reg <= res_nc_next;
        out_st_reg <= out_st_next;
        out_id_reg <= out_id_next;
        out_nc_reg <= out_nc_next;
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = out_st_reg;
    assign entry_id        = out_id_reg;
    assign newly_confirmed = out_nc_reg;

    // Table writes happen only on a match, an append or a compaction move
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CMP || state_reg == S_ADD || state_reg == S_RM_CHK))
        else $error("table write outside an update state");

    // Compaction never writes ahead of the read pointer
    a_wptr_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RM_RD || state_reg == S_RM_CHK) |-> (wptr_reg <= idx_reg))
        else $error("remove write pointer passed read pointer");

    // A new output word is only loaded from the result stage
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output loaded outside result stage");

    // A fresh result never overwrites a word the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_id_reg)))
        else $error("pending output word overwritten");

    // Fill counts stay within a zone's capacity
    for (genvar gz = 0; gz < ZONE_COUNT; gz++)
    begin : g_cnt_chk
        a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
            32'(cnt_reg[gz]) <= SLOTS_PER_ZONE)
            else $error("zone fill count beyond capacity");
    end

endmodule

// ===== hdl/dcct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dcct_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/dcct_sq_unit.sv =====
// Shared squaring unit: registered square of the difference of two coordinates.
`timescale 1ns / 1ps

module dcct_sq_unit (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [dcct_pkg::COORD_W-1:0] a,
    input  logic signed [dcct_pkg::COORD_W-1:0] b,
    output logic [dcct_pkg::SQ_W-1:0]           prod
);
    import dcct_pkg::*;

    logic signed [COORD_W:0] diff;
    logic signed [COORD_W:0] diff_abs;
    logic [COORD_W-1:0]      mag;
    logic [SQ_W-1:0]         prod_reg;

    // Form |a - b|; it always fits the coordinate width unsigned
    always_comb
    begin
        diff     = (COORD_W+1)'(a) - (COORD_W+1)'(b);
        diff_abs = diff[COORD_W] ? -diff : diff;
        mag      = diff_abs[COORD_W-1:0];
    end

    // Square and hold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

    assign prod = prod_reg;

endmodule
